FILE: sv/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants
// Item types, status codes and default sizes for the range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int unsigned NUM_REGIONS_DEF = 4;
  localparam int unsigned RANGES_DEF      = 16;
  localparam int unsigned OFFSET_BITS_DEF = 32;

  localparam logic [31:0] CAP_RESET    = 32'd65536;
  localparam logic [2:0]  ACTIVE_RESET = 3'd1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NO_FIT  = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_ACTIVE   = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_REG,
    S_A_EV,
    S_A_CHK,
    S_A_DEC,
    S_F_START,
    S_F_EV,
    S_F_DEC,
    S_F_ACT,
    S_SH_RD,
    S_SH_WR,
    S_WR0,
    S_WR1,
    S_FIN
  } fsm_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] req_size;
    logic [4:0]  align_log2;
    logic [1:0]  free_region;
    logic [31:0] free_offset;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [1:0]  grant_region;
    logic [31:0] grant_offset;
    logic [31:0] grant_size;
    logic [31:0] region_used;
  } rsp_t;

endpackage

FILE: sv/ffra_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/first_fit_range_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core: first-fit free-range allocator
// Allocates aligned slices from per-region sorted free-range tables held in
// one RAM, and coalesces freed slices with their neighbors.
// ----------------------------------------------------------------------------
// Steps: allocate visits each region in S_A_REG and scans each free range
//   through S_A_EV and S_A_CHK (align, fit check; the next RAM read issues
//   during the check); free scans each range in S_F_EV; an insert or removal
//   moves each entry through S_SH_RD and S_SH_WR, then S_WR0, S_WR1 and S_FIN.
// Items: one at a time, a new one taken only in S_IDLE; the single RAM port
//   pair sets the pace of scan and shift, and a stalled result holds the
//   next one back.
// Reset: counts, used bytes and fresh flags reset at once, no clearing pass;
//   a capacity or active config write re-initializes them.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_core #(
  parameter int unsigned NUM_REGIONS       = ffra_pkg::NUM_REGIONS_DEF,
  parameter int unsigned RANGES_PER_REGION = ffra_pkg::RANGES_DEF,
  parameter int unsigned OFFSET_BITS       = ffra_pkg::OFFSET_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  ffra_pkg::req_t  in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output ffra_pkg::rsp_t  out_item_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [31:0]     cfg_data_i
);

  localparam int unsigned NR    = NUM_REGIONS;
  localparam int unsigned R     = RANGES_PER_REGION;
  localparam int unsigned OB    = OFFSET_BITS;
  // arithmetic width: offsets plus alignment and size never carry past this
  localparam int unsigned AW    = ((OB > 32) ? OB : 32) + 2;
  localparam int unsigned CW    = $clog2(R + 1);
  localparam int unsigned RW    = (NR > 1) ? $clog2(NR) : 1;
  localparam int unsigned RCW   = $clog2(NR + 1);
  localparam int unsigned DEPTH = NR * R;
  localparam int unsigned AD    = $clog2(DEPTH);
  localparam int unsigned EW    = 2 * OB;

  function automatic logic [RCW-1:0] live_of(logic [2:0] act);
    return (32'(act) > NR) ? RCW'(NR) : RCW'(act);
  endfunction

  function automatic logic [CW-1:0] init_cnt(int unsigned k, logic [OB-1:0] cap,
                                             logic [2:0] act);
    return ((k < 32'(live_of(act))) && (cap != '0)) ? CW'(1) : '0;
  endfunction

  function automatic logic [AD-1:0] addr_of(logic [RCW-1:0] r, logic [CW-1:0] i);
    return AD'(32'(r) * R + 32'(i));
  endfunction

  // control and configuration
  ffra_pkg::fsm_e  state_q, state_d;
  logic [OB-1:0]   cap_q, cap_d;
  logic [2:0]      active_q, active_d;
  logic [CW-1:0]   cnt_q [NR];
  logic [CW-1:0]   cnt_d [NR];
  logic [31:0]     used_q [NR];
  logic [31:0]     used_d [NR];
  // region still holds its reset range (0, capacity) in entry 0, not yet in RAM
  logic [NR-1:0]   fresh_q, fresh_d;
  logic            out_valid_q, out_valid_d;

  // per-item working registers
  ffra_pkg::req_t  item_q, item_d;
  ffra_pkg::rsp_t  res_q, res_d, out_q, out_d;
  logic [RCW-1:0]  r_q, r_d;
  logic [CW-1:0]   idx_q, idx_d, n_q, n_d, rd_idx_q, rd_idx_d;
  logic [OB-1:0]   e_off_q, e_off_d;
  logic [AW-1:0]   al_q, al_d, end_q, end_d, pad_q, pad_d, post_off_q, post_off_d;
  logic [OB-1:0]   prev_off_q, prev_off_d, prev_len_q, prev_len_d;
  logic [OB-1:0]   next_off_q, next_off_d, next_len_q, next_len_d;
  logic            has_prev_q, has_prev_d, has_next_q, has_next_d;
  logic            mprev_q, mprev_d, mnext_q, mnext_d;
  logic [AW-1:0]   sum_q, sum_d;
  logic            sh_up_q, sh_up_d;
  logic [CW-1:0]   sh_j_q, sh_j_d, sh_s_q, sh_s_d;
  logic            wr0_en_q, wr0_en_d, wr1_en_q, wr1_en_d;
  logic [CW-1:0]   wr0_idx_q, wr0_idx_d, wr1_idx_q, wr1_idx_d;
  logic [EW-1:0]   wr0_ent_q, wr0_ent_d, wr1_ent_q, wr1_ent_d;

  // RAM port
  logic            ram_we, ram_re;
  logic [AD-1:0]   ram_waddr, ram_raddr;
  logic [EW-1:0]   ram_wdata, ram_rdata;
  logic [CW-1:0]   w_idx;

  // scratch
  logic [RW-1:0]   rr;
  logic [OB-1:0]   rd_off, rd_len;
  logic [AW-1:0]   a_m1, post_len, sz_ext, foff_ext;
  logic            fit, pad0, post0;

  ffra_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rr       = r_q[RW-1:0];
  assign sz_ext   = AW'(item_q.req_size);
  assign foff_ext = AW'(item_q.free_offset);
  assign a_m1     = (AW'(1) << item_q.align_log2) - AW'(1);

  // entry 0 of a fresh region reads as the full range
  always_comb begin
    if (fresh_q[rr] && (rd_idx_q == '0)) begin
      rd_off = '0;
      rd_len = cap_q;
    end else begin
      rd_off = ram_rdata[EW-1:OB];
      rd_len = ram_rdata[OB-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    cap_d       = cap_q;
    active_d    = active_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    fresh_d     = fresh_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    item_d      = item_q;
    res_d       = res_q;
    r_d         = r_q;
    idx_d       = idx_q;
    n_d         = n_q;
    rd_idx_d    = rd_idx_q;
    e_off_d     = e_off_q;
    al_d        = al_q;
    end_d       = end_q;
    pad_d       = pad_q;
    post_off_d  = post_off_q;
    prev_off_d  = prev_off_q;
    prev_len_d  = prev_len_q;
    next_off_d  = next_off_q;
    next_len_d  = next_len_q;
    has_prev_d  = has_prev_q;
    has_next_d  = has_next_q;
    mprev_d     = mprev_q;
    mnext_d     = mnext_q;
    sum_d       = sum_q;
    sh_up_d     = sh_up_q;
    sh_j_d      = sh_j_q;
    sh_s_d      = sh_s_q;
    wr0_en_d    = wr0_en_q;
    wr0_idx_d   = wr0_idx_q;
    wr0_ent_d   = wr0_ent_q;
    wr1_en_d    = wr1_en_q;
    wr1_idx_d   = wr1_idx_q;
    wr1_ent_d   = wr1_ent_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = '0;
    ram_raddr   = '0;
    ram_wdata   = '0;
    w_idx       = '0;
    fit         = 1'b0;
    post_len    = end_q - post_off_q;
    pad0        = (pad_q == '0);
    post0       = (post_len == '0);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ffra_pkg::S_IDLE: begin
        if (in_valid_i) begin
          item_d = in_item_i;
          res_d  = ffra_pkg::rsp_t'('0);
          if (in_item_i.req_size == '0) begin
            res_d.status = ffra_pkg::ST_INVALID;
            state_d      = ffra_pkg::S_FIN;
          end else if (in_item_i.opcode == ffra_pkg::OP_ALLOC) begin
            r_d     = '0;
            state_d = ffra_pkg::S_A_REG;
          end else if ((32'(in_item_i.free_region) >= 32'(live_of(active_q))) ||
                       ((AW'(in_item_i.free_offset) + AW'(in_item_i.req_size)) >
                        AW'(cap_q))) begin
            res_d.status = ffra_pkg::ST_INVALID;
            state_d      = ffra_pkg::S_FIN;
          end else begin
            r_d     = RCW'(in_item_i.free_region);
            state_d = ffra_pkg::S_F_START;
          end
        end
      end

      // ---- allocate: walk regions, then ranges -------------------------------
      ffra_pkg::S_A_REG: begin
        if (r_q >= live_of(active_q)) begin
          res_d.status = ffra_pkg::ST_NO_FIT;
          state_d      = ffra_pkg::S_FIN;
        end else if (cnt_q[rr] == '0) begin
          r_d = r_q + RCW'(1);
        end else begin
          n_d       = cnt_q[rr];
          idx_d     = '0;
          ram_re    = 1'b1;
          ram_raddr = addr_of(r_q, '0);
          rd_idx_d  = '0;
          state_d   = ffra_pkg::S_A_EV;
        end
      end

      ffra_pkg::S_A_EV: begin
        e_off_d = rd_off;
        al_d    = (AW'(rd_off) + a_m1) & ~a_m1;
        end_d   = AW'(rd_off) + AW'(rd_len);
        state_d = ffra_pkg::S_A_CHK;
      end

      ffra_pkg::S_A_CHK: begin
        pad_d      = al_q - AW'(e_off_q);
        post_off_d = al_q + sz_ext;
        fit        = (al_q < end_q) && ((al_q + sz_ext) <= end_q);
        if (fit) begin
          state_d = ffra_pkg::S_A_DEC;
        end else if ((idx_q + CW'(1)) < n_q) begin
          idx_d     = idx_q + CW'(1);
          ram_re    = 1'b1;
          ram_raddr = addr_of(r_q, idx_q + CW'(1));
          rd_idx_d  = idx_q + CW'(1);
          state_d   = ffra_pkg::S_A_EV;
        end else begin
          r_d     = r_q + RCW'(1);
          state_d = ffra_pkg::S_A_REG;
        end
      end

      ffra_pkg::S_A_DEC: begin
        res_d.grant_region = 2'(r_q);
        wr0_en_d = 1'b0;
        wr1_en_d = 1'b0;
        if (!pad0 && !post0 && (32'(n_q) >= R)) begin
          // split would overflow the table: refuse, nothing changes
          res_d.status      = ffra_pkg::ST_FULL;
          res_d.region_used = used_q[rr];
          state_d           = ffra_pkg::S_FIN;
        end else begin
          used_d[rr]         = used_q[rr] + item_q.req_size;
          res_d.status       = ffra_pkg::ST_OK;
          res_d.grant_offset = al_q[31:0];
          res_d.grant_size   = item_q.req_size;
          res_d.region_used  = used_q[rr] + item_q.req_size;
          state_d            = ffra_pkg::S_WR0;
          if (pad0 && post0) begin
            // exact fit: drop entry, close the gap
            cnt_d[rr] = n_q - CW'(1);
            sh_up_d   = 1'b0;
            sh_j_d    = idx_q + CW'(1);
            if ((idx_q + CW'(1)) < n_q) begin
              state_d = ffra_pkg::S_SH_RD;
            end
          end else if (pad0) begin
            wr0_en_d  = 1'b1;
            wr0_idx_d = idx_q;
            wr0_ent_d = {OB'(post_off_q), OB'(post_len)};
          end else if (post0) begin
            wr0_en_d  = 1'b1;
            wr0_idx_d = idx_q;
            wr0_ent_d = {e_off_q, OB'(pad_q)};
          end else begin
            // padding stays in place, tail goes into a new slot after it
            cnt_d[rr] = n_q + CW'(1);
            wr0_en_d  = 1'b1;
            wr0_idx_d = idx_q;
            wr0_ent_d = {e_off_q, OB'(pad_q)};
            wr1_en_d  = 1'b1;
            wr1_idx_d = idx_q + CW'(1);
            wr1_ent_d = {OB'(post_off_q), OB'(post_len)};
            sh_up_d   = 1'b1;
            sh_j_d    = n_q - CW'(1);
            sh_s_d    = idx_q + CW'(1);
            if (n_q > (idx_q + CW'(1))) begin
              state_d = ffra_pkg::S_SH_RD;
            end
          end
        end
      end

      // ---- free: find insert point, merge ------------------------------------
      ffra_pkg::S_F_START: begin
        n_d        = cnt_q[rr];
        idx_d      = '0;
        has_prev_d = 1'b0;
        has_next_d = 1'b0;
        if (cnt_q[rr] == '0) begin
          state_d = ffra_pkg::S_F_DEC;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = addr_of(r_q, '0);
          rd_idx_d  = '0;
          state_d   = ffra_pkg::S_F_EV;
        end
      end

      ffra_pkg::S_F_EV: begin
        if (AW'(rd_off) < foff_ext) begin
          prev_off_d = rd_off;
          prev_len_d = rd_len;
          has_prev_d = 1'b1;
          idx_d      = idx_q + CW'(1);
          if ((idx_q + CW'(1)) < n_q) begin
            ram_re    = 1'b1;
            ram_raddr = addr_of(r_q, idx_q + CW'(1));
            rd_idx_d  = idx_q + CW'(1);
          end else begin
            state_d = ffra_pkg::S_F_DEC;
          end
        end else begin
          next_off_d = rd_off;
          next_len_d = rd_len;
          has_next_d = 1'b1;
          state_d    = ffra_pkg::S_F_DEC;
        end
      end

      ffra_pkg::S_F_DEC: begin
        mnext_d = has_next_q && ((foff_ext + sz_ext) == AW'(next_off_q));
        mprev_d = has_prev_q && ((AW'(prev_off_q) + AW'(prev_len_q)) == foff_ext);
        sum_d   = AW'(prev_len_q) + sz_ext;
        state_d = ffra_pkg::S_F_ACT;
      end

      ffra_pkg::S_F_ACT: begin
        res_d.grant_region = 2'(r_q);
        wr0_en_d = 1'b1;
        wr1_en_d = 1'b0;
        if (!mnext_q && !mprev_q && (32'(n_q) >= R)) begin
          res_d.status      = ffra_pkg::ST_FULL;
          res_d.region_used = used_q[rr];
          wr0_en_d          = 1'b0;
          state_d           = ffra_pkg::S_FIN;
        end else begin
          // used count saturates at zero
          used_d[rr] = (used_q[rr] > item_q.req_size) ?
                       (used_q[rr] - item_q.req_size) : '0;
          res_d.status      = ffra_pkg::ST_OK;
          res_d.region_used = used_d[rr];
          state_d           = ffra_pkg::S_WR0;
          if (mprev_q && mnext_q) begin
            wr0_idx_d = idx_q - CW'(1);
            wr0_ent_d = {prev_off_q, OB'(sum_q + AW'(next_len_q))};
            cnt_d[rr] = n_q - CW'(1);
            sh_up_d   = 1'b0;
            sh_j_d    = idx_q + CW'(1);
            if ((idx_q + CW'(1)) < n_q) begin
              state_d = ffra_pkg::S_SH_RD;
            end
          end else if (mprev_q) begin
            wr0_idx_d = idx_q - CW'(1);
            wr0_ent_d = {prev_off_q, OB'(sum_q)};
          end else if (mnext_q) begin
            wr0_idx_d = idx_q;
            wr0_ent_d = {OB'(foff_ext), OB'(AW'(next_len_q) + sz_ext)};
          end else begin
            wr0_idx_d = idx_q;
            wr0_ent_d = {OB'(foff_ext), OB'(sz_ext)};
            cnt_d[rr] = n_q + CW'(1);
            sh_up_d   = 1'b1;
            sh_j_d    = n_q - CW'(1);
            sh_s_d    = idx_q;
            if (n_q > idx_q) begin
              state_d = ffra_pkg::S_SH_RD;
            end
          end
        end
      end

      // ---- entry move: read one, write it one slot up or down ----------------
      ffra_pkg::S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = addr_of(r_q, sh_j_q);
        rd_idx_d  = sh_j_q;
        state_d   = ffra_pkg::S_SH_WR;
      end

      ffra_pkg::S_SH_WR: begin
        ram_we    = 1'b1;
        w_idx     = sh_up_q ? (sh_j_q + CW'(1)) : (sh_j_q - CW'(1));
        ram_waddr = addr_of(r_q, w_idx);
        ram_wdata = {rd_off, rd_len};
        state_d   = ffra_pkg::S_SH_RD;
        if (sh_up_q) begin
          if (sh_j_q == sh_s_q) begin
            state_d = ffra_pkg::S_WR0;
          end else begin
            sh_j_d = sh_j_q - CW'(1);
          end
        end else begin
          if (sh_j_q == (n_q - CW'(1))) begin
            state_d = ffra_pkg::S_WR0;
          end else begin
            sh_j_d = sh_j_q + CW'(1);
          end
        end
      end

      ffra_pkg::S_WR0: begin
        if (wr0_en_q) begin
          ram_we    = 1'b1;
          w_idx     = wr0_idx_q;
          ram_waddr = addr_of(r_q, wr0_idx_q);
          ram_wdata = wr0_ent_q;
        end
        state_d = ffra_pkg::S_WR1;
      end

      ffra_pkg::S_WR1: begin
        if (wr1_en_q) begin
          ram_we    = 1'b1;
          w_idx     = wr1_idx_q;
          ram_waddr = addr_of(r_q, wr1_idx_q);
          ram_wdata = wr1_ent_q;
        end
        state_d = ffra_pkg::S_FIN;
      end

      ffra_pkg::S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ffra_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ffra_pkg::S_IDLE;
      end
    endcase

    // a real entry 0 now lives in RAM
    if (ram_we && (w_idx == '0)) begin
      fresh_d[rr] = 1'b0;
    end

    // a capacity or active config write re-initializes every table
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ffra_pkg::CFG_CAPACITY: begin
          cap_d = OB'(cfg_data_i);
        end
        ffra_pkg::CFG_ACTIVE: begin
          active_d = cfg_data_i[2:0];
        end
        default: begin
        end
      endcase
      if ((cfg_idx_i == ffra_pkg::CFG_CAPACITY) || (cfg_idx_i == ffra_pkg::CFG_ACTIVE)) begin
        for (int k = 0; k < NR; k++) begin
          cnt_d[k]  = init_cnt(k, cap_d, active_d);
          used_d[k] = '0;
        end
        fresh_d = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffra_pkg::S_IDLE;
      cap_q       <= OB'(ffra_pkg::CAP_RESET);
      active_q    <= ffra_pkg::ACTIVE_RESET;
      for (int k = 0; k < NR; k++) begin
        cnt_q[k]  <= init_cnt(k, OB'(ffra_pkg::CAP_RESET), ffra_pkg::ACTIVE_RESET);
        used_q[k] <= '0;
      end
      fresh_q     <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    item_q     <= item_d;
    res_q      <= res_d;
    r_q        <= r_d;
    idx_q      <= idx_d;
    n_q        <= n_d;
    rd_idx_q   <= rd_idx_d;
    e_off_q    <= e_off_d;
    al_q       <= al_d;
    end_q      <= end_d;
    pad_q      <= pad_d;
    post_off_q <= post_off_d;
    prev_off_q <= prev_off_d;
    prev_len_q <= prev_len_d;
    next_off_q <= next_off_d;
    next_len_q <= next_len_d;
    has_prev_q <= has_prev_d;
    has_next_q <= has_next_d;
    mprev_q    <= mprev_d;
    mnext_q    <= mnext_d;
    sum_q      <= sum_d;
    sh_up_q    <= sh_up_d;
    sh_j_q     <= sh_j_d;
    sh_s_q     <= sh_s_d;
    wr0_en_q   <= wr0_en_d;
    wr0_idx_q  <= wr0_idx_d;
    wr0_ent_q  <= wr0_ent_d;
    wr1_en_q   <= wr1_en_d;
    wr1_idx_q  <= wr1_idx_d;
    wr1_ent_q  <= wr1_ent_d;
  end

  assign in_stall_o  = (state_q != ffra_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
